/* rtl/rgbpo_pkg.sv */
// Shared types and constants of the RGB pixel point operation block.
// Depends on nothing; every other file in rtl refers to it by scoped names.
package rgbpo_pkg;

	typedef enum logic [2:0] {
		MODE_PASS     = 3'd0,
		MODE_RED      = 3'd1,
		MODE_GRAY     = 3'd2,
		MODE_THRESH   = 3'd3,
		MODE_BRIGHT   = 3'd4,
		MODE_CONTRAST = 3'd5,
		MODE_WHITEN   = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE         = 3'd0,
		REG_THRESHOLD    = 3'd1,
		REG_GAIN         = 3'd2,
		REG_TARGET_RED   = 3'd3,
		REG_TARGET_GREEN = 3'd4,
		REG_TARGET_BLUE  = 3'd5
	} reg_index_t;

	localparam int CFG_DATA_W = 16;

	localparam logic [7:0]  MID_LEVEL   = 8'd128;
	localparam logic [7:0]  FULL_LEVEL  = 8'd255;
	// Reciprocal of three in units of 2^-11, exact for sums up to 765.
	localparam logic [9:0]  THIRD_RECIP = 10'd683;
	localparam logic [25:0] CONTRAST_BIAS = 26'd32768;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic       last_in;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       last_out;
	} result_t;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  threshold;
		logic [15:0] gain;
		logic [7:0]  target_red;
		logic [7:0]  target_green;
		logic [7:0]  target_blue;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		pixel_t           pix;
		logic [9:0]       sum;
		logic [2:0][25:0] prod;
		logic [2:0][7:0]  adiff;
	} stage1_t;

	typedef struct packed {
		logic             valid;
		pixel_t           pix;
		logic [7:0]       avg;
		logic [2:0][7:0]  chan;
		logic [2:0][15:0] sq;
		logic [2:0][15:0] tsq;
	} stage2_t;

	typedef struct packed {
		logic            valid;
		pixel_t          pix;
		logic [7:0]      avg;
		logic [2:0][7:0] chan;
		logic [17:0]     dsum;
		logic [17:0]     nsum;
	} stage3_t;

endpackage

/* rtl/rgb_pixel_point_operation.sv */
// Top level of the RGB pixel point operation block: configuration registers and pipeline.
// Depends on rgbpo_pkg, rgbpo_front, rgbpo_mid and rgbpo_back.
//
// Channel   Ports                       Direction  Beat taken when
// pixel     start, busy, pixel          in         start high and busy low
// result    done, result                out        done high (cannot be held off)
// config    cfg_we, cfg_index, cfg_data in         cfg_we high
//
// A pixel beat is taken every cycle; busy is always low.
// Each result appears after its pixel has passed the four register stages, for one cycle, with done high.
// Four register stages: products and sums, saturation and squares,
// distance sums, result select; the gain multipliers set the first stage.
// Reset clears the stage valid bits and loads the register reset values.
module rgb_pixel_point_operation (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  rgbpo_pkg::pixel_t                   pixel,
	output logic                                done,
	output rgbpo_pkg::result_t                  result,
	input  logic                                cfg_we,
	input  logic [2:0]                          cfg_index,
	input  logic [rgbpo_pkg::CFG_DATA_W-1:0]    cfg_data
);

	rgbpo_pkg::cfg_t    cfg_q;
	rgbpo_pkg::stage1_t st_s1;
	rgbpo_pkg::stage2_t st_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= rgbpo_pkg::MODE_PASS;
			cfg_q.threshold    <= 8'd127;
			cfg_q.gain         <= 16'd256;
			cfg_q.target_red   <= 8'd0;
			cfg_q.target_green <= 8'd0;
			cfg_q.target_blue  <= 8'd0;
		end else if (cfg_we) begin
			case (rgbpo_pkg::reg_index_t'(cfg_index))
				rgbpo_pkg::REG_MODE:         cfg_q.mode <= rgbpo_pkg::mode_t'(cfg_data[2:0]);
				rgbpo_pkg::REG_THRESHOLD:    cfg_q.threshold <= cfg_data[7:0];
				rgbpo_pkg::REG_GAIN:         cfg_q.gain <= cfg_data;
				rgbpo_pkg::REG_TARGET_RED:   cfg_q.target_red <= cfg_data[7:0];
				rgbpo_pkg::REG_TARGET_GREEN: cfg_q.target_green <= cfg_data[7:0];
				rgbpo_pkg::REG_TARGET_BLUE:  cfg_q.target_blue <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	rgbpo_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.pix      (pixel),
		.cfg      (cfg_q),
		.st_s1    (st_s1)
	);

	rgbpo_mid u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.st_s1  (st_s1),
		.st_s2  (st_s2)
	);

	rgbpo_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.st_s2  (st_s2),
		.done   (done),
		.result (result)
	);

endmodule

/* rtl/rgbpo_front.sv */
// First pipeline stage: channel sum, gain products and distances to the target.
// Depends on rgbpo_pkg.
module rgbpo_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  rgbpo_pkg::pixel_t  pix,
	input  rgbpo_pkg::cfg_t    cfg,
	output rgbpo_pkg::stage1_t st_s1
);

	logic [2:0][7:0]  chan;
	logic [2:0][7:0]  tgt;
	logic [2:0][25:0] prod;
	logic [2:0][7:0]  adiff;

	assign chan = {pix.blue_in, pix.green_in, pix.red_in};
	assign tgt  = {cfg.target_blue, cfg.target_green, cfg.target_red};

	always_comb begin
		logic signed [8:0] op;
		logic signed [16:0] g;
		for (int i = 0; i < 3; i++) begin
			g = $signed({1'b0, cfg.gain});
			if (cfg.mode == rgbpo_pkg::MODE_CONTRAST) begin
				op = $signed({1'b0, chan[i]} - {1'b0, rgbpo_pkg::MID_LEVEL});
			end else begin
				op = $signed({1'b0, chan[i]});
			end
			prod[i] = 26'(g) * 26'(op);
			adiff[i] = (chan[i] > tgt[i]) ? (chan[i] - tgt[i]) : (tgt[i] - chan[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
		end else begin
			st_s1.valid <= in_valid;
			st_s1.pix   <= pix;
			st_s1.sum   <= 10'(pix.red_in) + 10'(pix.green_in) + 10'(pix.blue_in);
			st_s1.prod  <= prod;
			st_s1.adiff <= adiff;
		end
	end

endmodule

/* rtl/rgbpo_mid.sv */
// Second pipeline stage: average, saturated gain results, squared distances and squared targets.
// Depends on rgbpo_pkg.
module rgbpo_mid (
	input  logic               clk,
	input  logic               arst_n,
	input  rgbpo_pkg::cfg_t    cfg,
	input  rgbpo_pkg::stage1_t st_s1,
	output rgbpo_pkg::stage2_t st_s2
);

	logic [19:0]      avg_prod;
	logic [2:0][7:0]  chan;
	logic [2:0][7:0]  tgt;
	logic [2:0][15:0] sq;
	logic [2:0][15:0] tsq;

	assign avg_prod = 20'(st_s1.sum) * 20'(rgbpo_pkg::THIRD_RECIP);
	assign tgt = {cfg.target_blue, cfg.target_green, cfg.target_red};

	always_comb begin
		logic [25:0] v;
		for (int i = 0; i < 3; i++) begin
			v = st_s1.prod[i] + rgbpo_pkg::CONTRAST_BIAS;
			if (cfg.mode == rgbpo_pkg::MODE_CONTRAST) begin
				if (v[25]) begin
					chan[i] = 8'd0;
				end else if (v[24:16] != 9'd0) begin
					chan[i] = rgbpo_pkg::FULL_LEVEL;
				end else begin
					chan[i] = v[15:8];
				end
			end else begin
				if (st_s1.prod[i][25:16] != 10'd0) begin
					chan[i] = rgbpo_pkg::FULL_LEVEL;
				end else begin
					chan[i] = st_s1.prod[i][15:8];
				end
			end
			sq[i]  = 16'(st_s1.adiff[i]) * 16'(st_s1.adiff[i]);
			tsq[i] = 16'(tgt[i]) * 16'(tgt[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s2 <= '0;
		end else begin
			st_s2.valid <= st_s1.valid;
			st_s2.pix   <= st_s1.pix;
			st_s2.avg   <= avg_prod[18:11];
			st_s2.chan  <= chan;
			st_s2.sq    <= sq;
			st_s2.tsq   <= tsq;
		end
	end

endmodule

/* rtl/rgbpo_back.sv */
// Third and fourth pipeline stages: distance sums, whiten test and result select.
// Depends on rgbpo_pkg.
module rgbpo_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rgbpo_pkg::cfg_t    cfg,
	input  rgbpo_pkg::stage2_t st_s2,
	output logic               done,
	output rgbpo_pkg::result_t result
);

	rgbpo_pkg::stage3_t st_s3;
	logic [24:0]        d100;
	logic               white;
	logic               above;
	rgbpo_pkg::result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s3 <= '0;
		end else begin
			st_s3.valid <= st_s2.valid;
			st_s3.pix   <= st_s2.pix;
			st_s3.avg   <= st_s2.avg;
			st_s3.chan  <= st_s2.chan;
			st_s3.dsum  <= 18'(st_s2.sq[0]) + 18'(st_s2.sq[1]) + 18'(st_s2.sq[2]);
			st_s3.nsum  <= 18'(st_s2.tsq[0]) + 18'(st_s2.tsq[1]) + 18'(st_s2.tsq[2]);
		end
	end

	// Multiply by 100 as 64 + 32 + 4.
	assign d100  = {1'b0, st_s3.dsum, 6'd0} + {2'b0, st_s3.dsum, 5'd0}
		+ {5'b0, st_s3.dsum, 2'd0};
	assign white = (st_s3.nsum != 18'd0) && (d100 <= {7'd0, st_s3.nsum});
	assign above = st_s3.avg > cfg.threshold;

	always_comb begin
		res.red_out   = st_s3.pix.red_in;
		res.green_out = st_s3.pix.green_in;
		res.blue_out  = st_s3.pix.blue_in;
		res.last_out  = st_s3.pix.last_in;
		case (cfg.mode)
			rgbpo_pkg::MODE_RED: begin
				res.green_out = 8'd0;
				res.blue_out  = 8'd0;
			end
			rgbpo_pkg::MODE_GRAY: begin
				res.red_out   = st_s3.avg;
				res.green_out = st_s3.avg;
				res.blue_out  = st_s3.avg;
			end
			rgbpo_pkg::MODE_THRESH: begin
				res.red_out   = above ? rgbpo_pkg::FULL_LEVEL : 8'd0;
				res.green_out = above ? rgbpo_pkg::FULL_LEVEL : 8'd0;
				res.blue_out  = above ? rgbpo_pkg::FULL_LEVEL : 8'd0;
			end
			rgbpo_pkg::MODE_BRIGHT, rgbpo_pkg::MODE_CONTRAST: begin
				res.red_out   = st_s3.chan[0];
				res.green_out = st_s3.chan[1];
				res.blue_out  = st_s3.chan[2];
			end
			rgbpo_pkg::MODE_WHITEN: begin
				if (white) begin
					res.red_out   = rgbpo_pkg::FULL_LEVEL;
					res.green_out = rgbpo_pkg::FULL_LEVEL;
					res.blue_out  = rgbpo_pkg::FULL_LEVEL;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= st_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		result <= res;
	end

endmodule
